// ===== rtl/pfc_pkg.sv =====
`timescale 1ns / 1ps

package pfc_pkg;

   localparam int SYM_W       = 8;
   localparam int MAX_ENTRIES = 30;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int WORD3_W     = 48;

   typedef logic [SYM_W-1:0] sym_type;

   typedef struct packed {
      sym_type first;
      sym_type second;
   } pair_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SQUARE_WORD0 = 3'd0,
      CSR_SQUARE_WORD1 = 3'd1,
      CSR_SQUARE_WORD2 = 3'd2,
      CSR_SQUARE_WORD3 = 3'd3,
      CSR_DIRECTION    = 3'd4
   } csr_index_type;

endpackage

// ===== rtl/pfc_match.sv =====
`timescale 1ns / 1ps

module pfc_match #(
   parameter int ENTRIES = 30
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  pfc_pkg::pair_type               in_pair,
   input  pfc_pkg::sym_type [ENTRIES-1:0]  square,
   output logic                            out_valid,
   input  logic                            out_ready,
   output pfc_pkg::pair_type               out_pair,
   output logic [ENTRIES-1:0]              out_match_first,
   output logic [ENTRIES-1:0]              out_match_second
);
   import pfc_pkg::*;

   logic                valid_ff;
   pair_type            pair_ff;
   logic [ENTRIES-1:0]  match_first_ff, match_first_in;
   logic [ENTRIES-1:0]  match_second_ff, match_second_in;

   // compare both symbols against every square entry in parallel
   always_comb begin
      for (int k = 0; k < ENTRIES; k++) begin
         match_first_in[k]  = (square[k] == in_pair.first);
         match_second_in[k] = (square[k] == in_pair.second);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pair_ff         <= in_pair;
         match_first_ff  <= match_first_in;
         match_second_ff <= match_second_in;
      end
   end

   assign out_valid        = valid_ff;
   assign out_pair         = pair_ff;
   assign out_match_first  = match_first_ff;
   assign out_match_second = match_second_ff;

endmodule

// ===== rtl/pfc_locate.sv =====
`timescale 1ns / 1ps

module pfc_locate #(
   parameter int SQUARE_ROWS = 6,
   parameter int SQUARE_COLS = 5,
   localparam int ENTRIES    = SQUARE_ROWS * SQUARE_COLS,
   localparam int IDX_W      = $clog2(ENTRIES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pfc_pkg::pair_type   in_pair,
   input  logic [ENTRIES-1:0]  in_match_first,
   input  logic [ENTRIES-1:0]  in_match_second,
   input  logic                direction,
   output logic                out_valid,
   input  logic                out_ready,
   output pfc_pkg::pair_type   out_pair,
   output logic [IDX_W-1:0]    out_idx_first,
   output logic [IDX_W-1:0]    out_idx_second,
   output logic                out_not_found
);
   import pfc_pkg::*;

   localparam int ROW_W = $clog2(SQUARE_ROWS);
   localparam int COL_W = $clog2(SQUARE_COLS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SQUARE_ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(SQUARE_COLS - 1);
   localparam logic [IDX_W-1:0] COLS_IDX = IDX_W'(SQUARE_COLS);

   function automatic logic [COL_W-1:0] step_col(input logic [COL_W-1:0] c,
                                                 input logic dec);
      if (dec) begin
         step_col = (c == '0) ? LAST_COL : c - 1'b1;
      end else begin
         step_col = (c == LAST_COL) ? '0 : c + 1'b1;
      end
   endfunction

   function automatic logic [ROW_W-1:0] step_row(input logic [ROW_W-1:0] r,
                                                 input logic dec);
      if (dec) begin
         step_row = (r == '0) ? LAST_ROW : r - 1'b1;
      end else begin
         step_row = (r == LAST_ROW) ? '0 : r + 1'b1;
      end
   endfunction

   // stage a: first match to row and column
   logic              a_valid_ff;
   pair_type          a_pair_ff;
   logic [ROW_W-1:0]  a_row_first_ff, a_row_first_in;
   logic [COL_W-1:0]  a_col_first_ff, a_col_first_in;
   logic [ROW_W-1:0]  a_row_second_ff, a_row_second_in;
   logic [COL_W-1:0]  a_col_second_ff, a_col_second_in;
   logic              a_found_ff, a_found_in;
   logic              a_ready;

   // stage b: target positions as square indexes
   logic              b_valid_ff;
   pair_type          b_pair_ff;
   logic [IDX_W-1:0]  b_idx_first_ff, b_idx_first_in;
   logic [IDX_W-1:0]  b_idx_second_ff, b_idx_second_in;
   logic              b_not_found_ff;
   logic              b_ready;

   logic [ROW_W-1:0]  tgt_row_first, tgt_row_second;
   logic [COL_W-1:0]  tgt_col_first, tgt_col_second;

   // scan from the back so the lowest matching entry wins
   always_comb begin
      a_row_first_in  = '0;
      a_col_first_in  = '0;
      a_row_second_in = '0;
      a_col_second_in = '0;
      for (int r = SQUARE_ROWS - 1; r >= 0; r--) begin
         for (int c = SQUARE_COLS - 1; c >= 0; c--) begin
            if (in_match_first[r * SQUARE_COLS + c]) begin
               a_row_first_in = ROW_W'(r);
               a_col_first_in = COL_W'(c);
            end
            if (in_match_second[r * SQUARE_COLS + c]) begin
               a_row_second_in = ROW_W'(r);
               a_col_second_in = COL_W'(c);
            end
         end
      end
      a_found_in = (|in_match_first) && (|in_match_second);
   end

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && a_ready) begin
         a_pair_ff       <= in_pair;
         a_row_first_ff  <= a_row_first_in;
         a_col_first_ff  <= a_col_first_in;
         a_row_second_ff <= a_row_second_in;
         a_col_second_ff <= a_col_second_in;
         a_found_ff      <= a_found_in;
      end
   end

   always_comb begin
      if (a_row_first_ff == a_row_second_ff) begin
         tgt_row_first  = a_row_first_ff;
         tgt_row_second = a_row_second_ff;
         tgt_col_first  = step_col(a_col_first_ff, direction);
         tgt_col_second = step_col(a_col_second_ff, direction);
      end else if (a_col_first_ff == a_col_second_ff) begin
         tgt_row_first  = step_row(a_row_first_ff, direction);
         tgt_row_second = step_row(a_row_second_ff, direction);
         tgt_col_first  = a_col_first_ff;
         tgt_col_second = a_col_second_ff;
      end else begin
         tgt_row_first  = a_row_first_ff;
         tgt_row_second = a_row_second_ff;
         tgt_col_first  = a_col_second_ff;
         tgt_col_second = a_col_first_ff;
      end
      b_idx_first_in  = IDX_W'(tgt_row_first) * COLS_IDX + IDX_W'(tgt_col_first);
      b_idx_second_in = IDX_W'(tgt_row_second) * COLS_IDX + IDX_W'(tgt_col_second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff && b_ready) begin
         b_pair_ff       <= a_pair_ff;
         b_idx_first_ff  <= b_idx_first_in;
         b_idx_second_ff <= b_idx_second_in;
         b_not_found_ff  <= !a_found_ff;
      end
   end

   assign out_valid      = b_valid_ff;
   assign out_pair       = b_pair_ff;
   assign out_idx_first  = b_idx_first_ff;
   assign out_idx_second = b_idx_second_ff;
   assign out_not_found  = b_not_found_ff;

endmodule

// ===== rtl/pfc_lookup.sv =====
`timescale 1ns / 1ps

module pfc_lookup #(
   parameter int ENTRIES   = 30,
   localparam int IDX_W    = $clog2(ENTRIES)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  pfc_pkg::pair_type               in_pair,
   input  logic [IDX_W-1:0]                in_idx_first,
   input  logic [IDX_W-1:0]                in_idx_second,
   input  logic                            in_not_found,
   input  pfc_pkg::sym_type [ENTRIES-1:0]  square,
   output logic                            out_valid,
   input  logic                            out_ready,
   output pfc_pkg::sym_type                out_first,
   output pfc_pkg::sym_type                out_second,
   output logic                            out_not_found
);
   import pfc_pkg::*;

   logic     valid_ff;
   sym_type  first_ff, first_in;
   sym_type  second_ff, second_in;
   logic     not_found_ff;

   // absent symbol passes the pair through untouched
   always_comb begin
      if (in_not_found) begin
         first_in  = in_pair.first;
         second_in = in_pair.second;
      end else begin
         first_in  = square[in_idx_first];
         second_in = square[in_idx_second];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         first_ff     <= first_in;
         second_ff    <= second_in;
         not_found_ff <= in_not_found;
      end
   end

   assign out_valid     = valid_ff;
   assign out_first     = first_ff;
   assign out_second    = second_ff;
   assign out_not_found = not_found_ff;

endmodule

// ===== rtl/playfair_pair_cipher_unit.sv =====
`timescale 1ns / 1ps

// Playfair pair cipher over a SQUARE_ROWS x SQUARE_COLS key square of 8-bit
// symbols held in four square word registers (row-major, entry k in bits 8k
// upward) plus a direction bit (0 encrypt, 1 decrypt), written through the csr
// port, which is always ready. Each request yields exactly one response; a pair
// with a symbol missing from the square comes back unchanged with not_found set.
// The unit takes one request per cycle unless stalled and passes it through four
// register stages: match compare, first-match encode, target index, square read.
// Backpressure on rsp_ready stalls each stage only when the stage after it is
// full, so bubbles are squeezed out.

module playfair_pair_cipher_unit #(
   parameter int SQUARE_ROWS = 6,
   parameter int SQUARE_COLS = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pfc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pfc_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pfc_pkg::sym_type                      req_first_symbol,
   input  pfc_pkg::sym_type                      req_second_symbol,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pfc_pkg::sym_type                      rsp_first_out,
   output pfc_pkg::sym_type                      rsp_second_out,
   output logic                                  rsp_not_found
);
   import pfc_pkg::*;

   localparam int ENTRIES = SQUARE_ROWS * SQUARE_COLS;
   localparam int IDX_W   = $clog2(ENTRIES);

   logic [CSR_DATA_W-1:0]  square_word0_ff;
   logic [CSR_DATA_W-1:0]  square_word1_ff;
   logic [CSR_DATA_W-1:0]  square_word2_ff;
   logic [WORD3_W-1:0]     square_word3_ff;
   logic                   direction_ff;

   sym_type [MAX_ENTRIES-1:0]  square_all;
   sym_type [ENTRIES-1:0]      square;

   pair_type            req_pair;
   logic                m_valid, m_ready;
   pair_type            m_pair;
   logic [ENTRIES-1:0]  m_match_first, m_match_second;
   logic                l_valid, l_ready;
   pair_type            l_pair;
   logic [IDX_W-1:0]    l_idx_first, l_idx_second;
   logic                l_not_found;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         square_word0_ff <= '0;
         square_word1_ff <= '0;
         square_word2_ff <= '0;
         square_word3_ff <= '0;
         direction_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_SQUARE_WORD0: square_word0_ff <= csr_wdata;
            CSR_SQUARE_WORD1: square_word1_ff <= csr_wdata;
            CSR_SQUARE_WORD2: square_word2_ff <= csr_wdata;
            CSR_SQUARE_WORD3: square_word3_ff <= csr_wdata[WORD3_W-1:0];
            CSR_DIRECTION:    direction_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign square_all = {square_word3_ff, square_word2_ff, square_word1_ff, square_word0_ff};
   assign square     = square_all[ENTRIES-1:0];

   assign req_pair.first  = req_first_symbol;
   assign req_pair.second = req_second_symbol;

   pfc_match #(
      .ENTRIES (ENTRIES)
   ) u_match (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (req_valid),
      .in_ready         (req_ready),
      .in_pair          (req_pair),
      .square           (square),
      .out_valid        (m_valid),
      .out_ready        (m_ready),
      .out_pair         (m_pair),
      .out_match_first  (m_match_first),
      .out_match_second (m_match_second)
   );

   pfc_locate #(
      .SQUARE_ROWS (SQUARE_ROWS),
      .SQUARE_COLS (SQUARE_COLS)
   ) u_locate (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (m_valid),
      .in_ready        (m_ready),
      .in_pair         (m_pair),
      .in_match_first  (m_match_first),
      .in_match_second (m_match_second),
      .direction       (direction_ff),
      .out_valid       (l_valid),
      .out_ready       (l_ready),
      .out_pair        (l_pair),
      .out_idx_first   (l_idx_first),
      .out_idx_second  (l_idx_second),
      .out_not_found   (l_not_found)
   );

   pfc_lookup #(
      .ENTRIES (ENTRIES)
   ) u_lookup (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (l_valid),
      .in_ready      (l_ready),
      .in_pair       (l_pair),
      .in_idx_first  (l_idx_first),
      .in_idx_second (l_idx_second),
      .in_not_found  (l_not_found),
      .square        (square),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_first     (rsp_first_out),
      .out_second    (rsp_second_out),
      .out_not_found (rsp_not_found)
   );

endmodule
